FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands shared by the sender's RTL modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define CAS_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// A condition that must be followed by another one on the next edge.
`define CAS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: hw/rtl/cas_pkg.sv
// ----------------------------------------------------------------------------
// cas_pkg
// Shared constants, field types, codes and control structs of the sender.
// ----------------------------------------------------------------------------
`default_nettype none

package cas_pkg;

	// Message geometry.
	localparam int CHUNK_BYTES = 221;
	localparam int MAX_CHUNKS  = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int TAG_BITS    = 64;
	localparam int MAX_LEN     = MAX_CHUNKS * CHUNK_BYTES;

	// Field widths.
	localparam int FUNC_W    = 2;
	localparam int TAG_W     = 64;
	localparam int PLEN_W    = 16;
	localparam int ID_W      = 32;
	localparam int MAP_W     = 32;
	localparam int KIND_W    = 3;
	localparam int SEQ_W     = 6;
	localparam int LEN_W     = 13;
	localparam int RETRY_W   = 4;
	localparam int RLEFT_W   = 5;
	localparam int START_W   = 3;
	localparam int POP_W     = $clog2(MAP_W + 1);
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 4;
	localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

	// Chunk count by reciprocal multiplication: exact for every operand
	// below 2^17 because the rounding error of the multiplier is below
	// one chunk size.
	localparam int DIVX_W      = PLEN_W + 1;
	localparam int RECIP_SHIFT = 32;
	localparam longint unsigned RECIP_MULT =
		((64'd1 << RECIP_SHIFT) + CHUNK_BYTES - 1) / CHUNK_BYTES;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int PROD_W      = DIVX_W + RECIP_W;

	localparam logic [TAG_W-1:0] TAG_MASK = {TAG_W{1'b1}} >> (TAG_W - TAG_BITS);

	// Register reset values.
	localparam logic [RETRY_W-1:0] RETRY_BUDGET_RST = 4'd5;
	localparam logic [START_W-1:0] START_REPEAT_RST = 3'd3;

	// Outcome flag codes (bit 0 ok, bit 1 failed).
	localparam logic [1:0] OUTCOME_NONE = 2'b00;
	localparam logic [1:0] OUTCOME_OK   = 2'b01;
	localparam logic [1:0] OUTCOME_FAIL = 2'b10;

	typedef logic [TAG_W-1:0]   tag_t;
	typedef logic [ID_W-1:0]    id_t;
	typedef logic [LEN_W-1:0]   len_t;
	typedef logic [SEQ_W-1:0]   seq_t;
	typedef logic [MAP_W-1:0]   map_t;
	typedef logic [PLEN_W-1:0]  plen_t;
	typedef logic [QPTR_W-1:0]  qptr_t;
	typedef logic [QCNT_W-1:0]  qcnt_t;
	typedef logic [RLEFT_W-1:0] rleft_t;
	typedef logic [START_W-1:0] starts_t;
	typedef logic [POP_W-1:0]   pop_t;
	typedef logic [DIVX_W-1:0]  divx_t;
	typedef logic [PROD_W-1:0]  prod_t;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_TICK = 2'd0,
		FUNC_ENQ  = 2'd1,
		FUNC_ACK  = 2'd2,
		FUNC_NONE = 2'd3
	} func_e;

	typedef enum logic [KIND_W-1:0] {
		KIND_START  = 3'd0,
		KIND_DATA   = 3'd1,
		KIND_END    = 3'd2,
		KIND_ACCEPT = 3'd3,
		KIND_REFUSE = 3'd4
	} kind_e;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_START = 2'd1,
		MODE_DATA  = 2'd2
	} mode_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RETRY_BUDGET = 1'd0,
		CFG_START_REPEAT = 1'd1
	} cfg_idx_e;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_EXEC = 2'd1,
		ST_END2 = 2'd2
	} state_e;

	// Controller to datapath.
	typedef struct packed {
		logic capture;
		logic exec;
		logic end2;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic two_ends;
	} sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/chunked_arq_sender.sv
// ----------------------------------------------------------------------------
// chunked_arq_sender
// Sender controller for chunked messages with selective bitmap
// acknowledgements. A word is accepted at a rising edge where start is high
// and busy is low. Its results appear on the result ports one cycle at a
// time, each marked by strobe for exactly one cycle, and the receiver cannot
// stall them: whatever is attached must take every strobed word as it comes.
// An item yields at most two words. The execute state follows the accepting
// edge, and busy is high while it lasts. The first word is registered at the
// edge that ends the execute state and is on the ports from then on. A new
// word is accepted only once busy is low again. An item that closes a message
// (two END words) keeps busy high through the second END state as well, and
// its second END word directly follows the first. This order is set by the
// controller's one execute state feeding a single registered result port.
// Ticks, enqueues and acknowledgements that produce no result still pass
// through the execute state.
// ----------------------------------------------------------------------------
`default_nettype none

module chunked_arq_sender (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Command channel.
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [cas_pkg::FUNC_W-1:0]    func,
	input  wire logic [cas_pkg::TAG_W-1:0]     conv_tag,
	input  wire logic [cas_pkg::PLEN_W-1:0]    payload_len,
	input  wire logic [cas_pkg::ID_W-1:0]      ack_msg_id,
	input  wire logic [cas_pkg::MAP_W-1:0]     ack_bitmap,
	// Configuration write port.
	input  wire logic                          cfg_we,
	input  wire logic [cas_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [cas_pkg::CFG_DAT_W-1:0] cfg_wdata,
	// Result channel.
	output logic                               strobe,
	output logic [cas_pkg::KIND_W-1:0]         kind,
	output logic [cas_pkg::ID_W-1:0]           out_msg_id,
	output logic [cas_pkg::TAG_W-1:0]          out_conv_tag,
	output logic [cas_pkg::SEQ_W-1:0]          seq_number,
	output logic [cas_pkg::SEQ_W-1:0]          seq_total,
	output logic [cas_pkg::LEN_W-1:0]          chunk_offset,
	output logic [cas_pkg::LEN_W-1:0]          chunk_bytes,
	output logic                               busy_res,
	output logic                               done_ok,
	output logic                               done_failed,
	output logic                               last
);

	// The controller only sequences: capture the accepted word, execute it,
	// and, when the datapath reports that the item closed a message, repeat
	// the END word in a second END state.
	cas_pkg::cmd_t cmd;
	cas_pkg::sts_t sts;

	cas_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	// The datapath holds the outbox, the message in flight and the result
	// register. Configuration writes land there directly; the user must issue
	// them only while the block is idle, which the block does not enforce.
	cas_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.func         (func),
		.conv_tag     (conv_tag),
		.payload_len  (payload_len),
		.ack_msg_id   (ack_msg_id),
		.ack_bitmap   (ack_bitmap),
		.strobe       (strobe),
		.kind         (kind),
		.out_msg_id   (out_msg_id),
		.out_conv_tag (out_conv_tag),
		.seq_number   (seq_number),
		.seq_total    (seq_total),
		.chunk_offset (chunk_offset),
		.chunk_bytes  (chunk_bytes),
		.busy_res     (busy_res),
		.done_ok      (done_ok),
		.done_failed  (done_failed),
		.last         (last)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/cas_ctrl.sv
// ----------------------------------------------------------------------------
// cas_ctrl
// Sequencer of the sender: capture a word, execute it, and issue a second
// END word when the executed item closes a message.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cas_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	output cas_pkg::cmd_t      cmd,
	input  wire cas_pkg::sts_t sts
);

	cas_pkg::state_e state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cas_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			cas_pkg::ST_IDLE: begin
				if (start) state_nxt = cas_pkg::ST_EXEC;
			end
			cas_pkg::ST_EXEC: begin
				state_nxt = sts.two_ends ? cas_pkg::ST_END2 : cas_pkg::ST_IDLE;
			end
			cas_pkg::ST_END2: begin
				state_nxt = cas_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = cas_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy        = (state_q != cas_pkg::ST_IDLE);
		cmd.capture = (state_q == cas_pkg::ST_IDLE) && start;
		cmd.exec    = (state_q == cas_pkg::ST_EXEC);
		cmd.end2    = (state_q == cas_pkg::ST_END2);
	end

	`CAS_ASSERT_NEXT(a_exec_one_cycle, state_q == cas_pkg::ST_EXEC, state_q != cas_pkg::ST_EXEC, "execute state held for more than one cycle")
	`CAS_ASSERT_CLK(a_end2_after_exec, (state_q == cas_pkg::ST_END2) |-> ($past(state_q) == cas_pkg::ST_EXEC && $past(sts.two_ends)), "second END without a closing item")
	`CAS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")

endmodule

`default_nettype wire

FILE: hw/rtl/cas_dpath.sv
// ----------------------------------------------------------------------------
// cas_dpath
// Datapath of the sender: item capture, outbox, message state, chunk
// selection and the registered result port.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cas_dpath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire cas_pkg::cmd_t                       cmd,
	output cas_pkg::sts_t                            sts,
	input  wire logic                                cfg_we,
	input  wire logic [cas_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [cas_pkg::CFG_DAT_W-1:0]       cfg_wdata,
	input  wire logic [cas_pkg::FUNC_W-1:0]          func,
	input  wire logic [cas_pkg::TAG_W-1:0]           conv_tag,
	input  wire logic [cas_pkg::PLEN_W-1:0]          payload_len,
	input  wire logic [cas_pkg::ID_W-1:0]            ack_msg_id,
	input  wire logic [cas_pkg::MAP_W-1:0]           ack_bitmap,
	output logic                                     strobe,
	output logic [cas_pkg::KIND_W-1:0]               kind,
	output logic [cas_pkg::ID_W-1:0]                 out_msg_id,
	output logic [cas_pkg::TAG_W-1:0]                out_conv_tag,
	output logic [cas_pkg::SEQ_W-1:0]                seq_number,
	output logic [cas_pkg::SEQ_W-1:0]                seq_total,
	output logic [cas_pkg::LEN_W-1:0]                chunk_offset,
	output logic [cas_pkg::LEN_W-1:0]                chunk_bytes,
	output logic                                     busy_res,
	output logic                                     done_ok,
	output logic                                     done_failed,
	output logic                                     last
);

	localparam int QSUM_W = cas_pkg::QCNT_W + 1;

	function automatic cas_pkg::pop_t popcount(input cas_pkg::map_t v);
		cas_pkg::pop_t n;
		n = '0;
		for (int b = 0; b < cas_pkg::MAP_W; b++) begin
			n = n + cas_pkg::pop_t'(v[b]);
		end
		return n;
	endfunction

	// Configuration registers.
	logic [cas_pkg::RETRY_W-1:0] retry_budget_q;
	cas_pkg::starts_t            start_repeat_q;

	// Captured item.
	cas_pkg::func_e item_func_q;
	cas_pkg::tag_t  item_tag_q;
	cas_pkg::plen_t item_len_q;
	cas_pkg::id_t   item_id_q;
	cas_pkg::map_t  item_map_q;

	// Outbox.
	cas_pkg::id_t  q_ids_q    [cas_pkg::QUEUE_DEPTH];
	cas_pkg::tag_t q_tags_q   [cas_pkg::QUEUE_DEPTH];
	cas_pkg::len_t q_lens_q   [cas_pkg::QUEUE_DEPTH];
	cas_pkg::seq_t q_totals_q [cas_pkg::QUEUE_DEPTH];
	cas_pkg::qptr_t head_q, head_inc, tail;
	cas_pkg::qcnt_t count_q, count_nxt;
	logic [QSUM_W-1:0] tail_sum;

	// Message state.
	cas_pkg::mode_e   mode_q, mode_nxt;
	cas_pkg::id_t     next_id_q, next_id_nxt;
	cas_pkg::id_t     cur_id_q, cur_id_nxt;
	cas_pkg::tag_t    cur_tag_q, cur_tag_nxt;
	cas_pkg::len_t    cur_len_q, cur_len_nxt;
	cas_pkg::seq_t    cur_total_q, cur_total_nxt;
	cas_pkg::map_t    acked_q, acked_nxt;
	cas_pkg::rleft_t  retries_q, retries_nxt;
	cas_pkg::starts_t starts_q, starts_nxt;
	cas_pkg::seq_t    prev_chunk_q, prev_chunk_nxt;
	logic             prev_valid_q, prev_valid_nxt;
	logic [1:0]       outcome_q, outcome_nxt;

	// Execute-cycle logic.
	logic             load, deq, enq_write, enq_ok, ack_match, do_ends, has_pending;
	cas_pkg::mode_e   eff_mode;
	cas_pkg::id_t     eff_id;
	cas_pkg::tag_t    eff_tag;
	cas_pkg::len_t    eff_len;
	cas_pkg::seq_t    eff_total;
	cas_pkg::map_t    eff_acked, lim_mask, pending, new_mask;
	cas_pkg::rleft_t  eff_retries;
	cas_pkg::starts_t eff_starts;
	logic             eff_prev_valid;
	cas_pkg::seq_t    chunk_idx;
	cas_pkg::len_t    chunk_off, chunk_rem, chunk_len;
	cas_pkg::divx_t   enq_divx;
	cas_pkg::prod_t   enq_prod;
	cas_pkg::seq_t    enq_total;

	// Result in flight toward the output register.
	logic           res_emit;
	cas_pkg::kind_e res_kind;
	cas_pkg::id_t   res_id;
	cas_pkg::tag_t  res_tag;
	cas_pkg::seq_t  res_seq, res_total;
	cas_pkg::len_t  res_off, res_bytes;

	// Output register.
	logic           strobe_q;
	cas_pkg::kind_e kind_q;
	cas_pkg::id_t   out_id_q;
	cas_pkg::tag_t  out_tag_q;
	cas_pkg::seq_t  seq_q, total_q;
	cas_pkg::len_t  off_q, bytes_q;
	logic           busy_res_q, ok_q, fail_q, last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_budget_q <= cas_pkg::RETRY_BUDGET_RST;
			start_repeat_q <= cas_pkg::START_REPEAT_RST;
		end else if (cfg_we) begin
			unique case (cas_pkg::cfg_idx_e'(cfg_index))
				cas_pkg::CFG_RETRY_BUDGET: retry_budget_q <= cfg_wdata[cas_pkg::RETRY_W-1:0];
				cas_pkg::CFG_START_REPEAT: start_repeat_q <= cfg_wdata[cas_pkg::START_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_func_q <= cas_pkg::func_e'(func);
			item_tag_q  <= conv_tag & cas_pkg::TAG_MASK;
			item_len_q  <= payload_len;
			item_id_q   <= ack_msg_id;
			item_map_q  <= ack_bitmap;
		end
	end

	// Ring pointers; head plus count stays below twice the depth.
	always_comb begin
		tail_sum = QSUM_W'(head_q) + QSUM_W'(count_q);
		tail     = (tail_sum >= QSUM_W'(cas_pkg::QUEUE_DEPTH))
			? cas_pkg::qptr_t'(tail_sum - QSUM_W'(cas_pkg::QUEUE_DEPTH))
			: cas_pkg::qptr_t'(tail_sum);
		head_inc = (head_q == cas_pkg::qptr_t'(cas_pkg::QUEUE_DEPTH - 1))
			? '0 : head_q + 1'b1;
	end

	// Operands as they stand once a tick has pulled the outbox head.
	always_comb begin
		load = (item_func_q == cas_pkg::FUNC_TICK) && (mode_q == cas_pkg::MODE_IDLE)
			&& (count_q != '0);
		eff_mode       = load ? cas_pkg::MODE_START : mode_q;
		eff_id         = load ? q_ids_q[head_q] : cur_id_q;
		eff_tag        = load ? q_tags_q[head_q] : cur_tag_q;
		eff_len        = load ? q_lens_q[head_q] : cur_len_q;
		eff_total      = load ? q_totals_q[head_q] : cur_total_q;
		eff_acked      = load ? '0 : acked_q;
		eff_retries    = load ? cas_pkg::rleft_t'(retry_budget_q) : retries_q;
		eff_starts     = load ? start_repeat_q : starts_q;
		eff_prev_valid = load ? 1'b0 : prev_valid_q;
	end

	// Lowest chunk that is not yet acknowledged, and its extent.
	always_comb begin
		for (int b = 0; b < cas_pkg::MAP_W; b++) begin
			lim_mask[b] = (cas_pkg::seq_t'(b) < eff_total);
		end
		pending     = ~eff_acked & lim_mask;
		has_pending = |pending;
		chunk_idx   = '0;
		for (int b = cas_pkg::MAP_W - 1; b >= 0; b--) begin
			if (pending[b]) chunk_idx = cas_pkg::seq_t'(b);
		end
		chunk_off = cas_pkg::len_t'(chunk_idx) * cas_pkg::len_t'(cas_pkg::CHUNK_BYTES);
		chunk_rem = (eff_len > chunk_off) ? eff_len - chunk_off : '0;
		chunk_len = (chunk_rem > cas_pkg::len_t'(cas_pkg::CHUNK_BYTES))
			? cas_pkg::len_t'(cas_pkg::CHUNK_BYTES) : chunk_rem;
	end

	// Chunk count of an enqueued message, rounded up, at least one.
	always_comb begin
		enq_divx  = cas_pkg::divx_t'(item_len_q) + cas_pkg::divx_t'(cas_pkg::CHUNK_BYTES - 1);
		enq_prod  = cas_pkg::prod_t'(enq_divx) * cas_pkg::prod_t'(cas_pkg::RECIP_MULT);
		enq_total = enq_prod[cas_pkg::RECIP_SHIFT +: cas_pkg::SEQ_W];
		if (enq_total == '0) enq_total = cas_pkg::seq_t'(1);
	end

	always_comb begin
		enq_ok = (item_len_q <= cas_pkg::plen_t'(cas_pkg::MAX_LEN))
			&& (count_q < cas_pkg::qcnt_t'(cas_pkg::QUEUE_DEPTH));
		new_mask  = acked_q | item_map_q;
		ack_match = (mode_q != cas_pkg::MODE_IDLE) && (item_id_q == cur_id_q)
			&& (item_tag_q == cur_tag_q);

		mode_nxt       = mode_q;
		next_id_nxt    = next_id_q;
		cur_id_nxt     = cur_id_q;
		cur_tag_nxt    = cur_tag_q;
		cur_len_nxt    = cur_len_q;
		cur_total_nxt  = cur_total_q;
		acked_nxt      = acked_q;
		retries_nxt    = retries_q;
		starts_nxt     = starts_q;
		prev_chunk_nxt = prev_chunk_q;
		prev_valid_nxt = prev_valid_q;
		outcome_nxt    = outcome_q;
		deq            = 1'b0;
		enq_write      = 1'b0;
		do_ends        = 1'b0;
		res_emit       = 1'b0;
		res_kind       = cas_pkg::KIND_START;
		res_id         = '0;
		res_tag        = '0;
		res_seq        = '0;
		res_total      = '0;
		res_off        = '0;
		res_bytes      = '0;

		unique case (item_func_q)
			cas_pkg::FUNC_TICK: begin
				if ((mode_q != cas_pkg::MODE_IDLE) || (count_q != '0)) begin
					deq            = load;
					cur_id_nxt     = eff_id;
					cur_tag_nxt    = eff_tag;
					cur_len_nxt    = eff_len;
					cur_total_nxt  = eff_total;
					acked_nxt      = eff_acked;
					retries_nxt    = eff_retries;
					starts_nxt     = eff_starts;
					prev_valid_nxt = eff_prev_valid;
					if (eff_mode == cas_pkg::MODE_START) begin
						res_emit  = 1'b1;
						res_kind  = cas_pkg::KIND_START;
						res_id    = eff_id;
						res_tag   = eff_tag;
						res_total = eff_total;
						res_bytes = eff_len;
						if (eff_starts <= cas_pkg::starts_t'(1)) begin
							starts_nxt     = '0;
							mode_nxt       = cas_pkg::MODE_DATA;
							prev_valid_nxt = 1'b0;
						end else begin
							starts_nxt = eff_starts - 1'b1;
							mode_nxt   = cas_pkg::MODE_START;
						end
					end else if (!has_pending) begin
						do_ends = 1'b1;
					end else begin
						res_emit       = 1'b1;
						res_kind       = cas_pkg::KIND_DATA;
						res_id         = eff_id;
						res_tag        = eff_tag;
						res_seq        = chunk_idx;
						res_total      = eff_total;
						res_off        = chunk_off;
						res_bytes      = chunk_len;
						prev_chunk_nxt = chunk_idx;
						prev_valid_nxt = 1'b1;
						// The same chunk twice in a row is a resend.
						if (eff_prev_valid && (prev_chunk_q == chunk_idx)) begin
							if (eff_retries == '0) begin
								mode_nxt    = cas_pkg::MODE_IDLE;
								outcome_nxt = cas_pkg::OUTCOME_FAIL;
							end else begin
								retries_nxt = eff_retries - 1'b1;
							end
						end
					end
				end
			end
			cas_pkg::FUNC_ENQ: begin
				res_emit = 1'b1;
				res_tag  = item_tag_q;
				if (enq_ok) begin
					res_kind    = cas_pkg::KIND_ACCEPT;
					res_id      = next_id_q;
					enq_write   = 1'b1;
					next_id_nxt = next_id_q + 1'b1;
				end else begin
					res_kind = cas_pkg::KIND_REFUSE;
				end
			end
			cas_pkg::FUNC_ACK: begin
				if (ack_match) begin
					acked_nxt = new_mask;
					if (cas_pkg::pop_t'(cur_total_q) <= popcount(new_mask)) begin
						do_ends = 1'b1;
					end else begin
						mode_nxt = cas_pkg::MODE_DATA;
					end
				end
			end
			cas_pkg::FUNC_NONE: begin
			end
			default: begin
			end
		endcase

		if (do_ends) begin
			res_emit    = 1'b1;
			res_kind    = cas_pkg::KIND_END;
			res_id      = eff_id;
			res_tag     = eff_tag;
			res_seq     = eff_total;
			res_total   = eff_total;
			mode_nxt    = cas_pkg::MODE_IDLE;
			outcome_nxt = cas_pkg::OUTCOME_OK;
		end

		count_nxt = count_q;
		if (enq_write) count_nxt = count_q + 1'b1;
		else if (deq)  count_nxt = count_q - 1'b1;

		sts.two_ends = do_ends;
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && enq_write) begin
			q_ids_q[tail]    <= next_id_q;
			q_tags_q[tail]   <= item_tag_q;
			q_lens_q[tail]   <= cas_pkg::len_t'(item_len_q);
			q_totals_q[tail] <= enq_total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= cas_pkg::MODE_IDLE;
			head_q       <= '0;
			count_q      <= '0;
			next_id_q    <= '0;
			cur_id_q     <= '0;
			cur_tag_q    <= '0;
			cur_len_q    <= '0;
			cur_total_q  <= '0;
			acked_q      <= '0;
			retries_q    <= '0;
			starts_q     <= '0;
			prev_chunk_q <= '0;
			prev_valid_q <= 1'b0;
			outcome_q    <= cas_pkg::OUTCOME_NONE;
		end else if (cmd.exec) begin
			mode_q       <= mode_nxt;
			if (deq) head_q <= head_inc;
			count_q      <= count_nxt;
			next_id_q    <= next_id_nxt;
			cur_id_q     <= cur_id_nxt;
			cur_tag_q    <= cur_tag_nxt;
			cur_len_q    <= cur_len_nxt;
			cur_total_q  <= cur_total_nxt;
			acked_q      <= acked_nxt;
			retries_q    <= retries_nxt;
			starts_q     <= starts_nxt;
			prev_chunk_q <= prev_chunk_nxt;
			prev_valid_q <= prev_valid_nxt;
			outcome_q    <= outcome_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (cmd.exec && res_emit) || cmd.end2;
		end
	end

	// The second END repeats the first, now marked as the final word.
	always_ff @(posedge clk) begin
		if (cmd.exec && res_emit) begin
			kind_q     <= res_kind;
			out_id_q   <= res_id;
			out_tag_q  <= res_tag;
			seq_q      <= res_seq;
			total_q    <= res_total;
			off_q      <= res_off;
			bytes_q    <= res_bytes;
			busy_res_q <= (mode_nxt != cas_pkg::MODE_IDLE);
			ok_q       <= outcome_nxt[0];
			fail_q     <= outcome_nxt[1];
			last_q     <= !do_ends;
		end else if (cmd.end2) begin
			last_q <= 1'b1;
		end
	end

	assign strobe       = strobe_q;
	assign kind         = kind_q;
	assign out_msg_id   = out_id_q;
	assign out_conv_tag = out_tag_q;
	assign seq_number   = seq_q;
	assign seq_total    = total_q;
	assign chunk_offset = off_q;
	assign chunk_bytes  = bytes_q;
	assign busy_res     = busy_res_q;
	assign done_ok      = ok_q;
	assign done_failed  = fail_q;
	assign last         = last_q;

	`CAS_ASSERT_CLK(a_count_bound, count_q <= cas_pkg::qcnt_t'(cas_pkg::QUEUE_DEPTH), "outbox count beyond depth")
	`CAS_ASSERT_NEXT(a_end_pair, strobe_q && !last_q, strobe_q && last_q && (kind_q == cas_pkg::KIND_END), "first END not followed by the final END")
	`CAS_ASSERT_CLK(a_data_seq, (strobe_q && (kind_q == cas_pkg::KIND_DATA)) |-> (seq_q < total_q), "DATA chunk index beyond chunk total")

endmodule

`default_nettype wire
